FILE: hw/rtl/fpr_pkg.sv
// shared types, codes and the crc-16/ccitt-false byte update for the frame receiver
// no dependencies; imported by framed_packet_receiver_crc16, fpr_checker and tb_top
package fpr_pkg;

    localparam int DEF_MAX_PAYLOAD   = 32;
    localparam int DEF_COUNTER_WIDTH = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_FIRST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOF_SECOND  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 2'd2;

    localparam logic [7:0] SOF_FIRST_RST   = 8'hAA;
    localparam logic [7:0] SOF_SECOND_RST  = 8'h55;
    localparam logic [7:0] EXP_VERSION_RST = 8'h01;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_PACKET  = 3'd1,
        ST_FORMAT  = 3'd2,
        ST_VERSION = 3'd3,
        ST_CRC     = 3'd4
    } fpr_status_t;

    // msb-first crc update by one byte, eight shift steps
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/framed_packet_receiver_crc16.sv
// framed packet receiver: marker hunt, header, payload buffer, crc-16 check
// depends on fpr_pkg; payload buffer is a synchronous memory with a registered read inside
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------
//  input    | in        | in_valid / in_ready  | rx_byte
//  result   | out       | out_valid/ out_ready | status .. byte_index, last, totals
//  config   | in        | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// every received byte is taken while the result slot is free and gives one result,
// except the closing crc byte of a good frame with n > 0 payload bytes, which gives none;
//   that payload then plays out of the buffer, each result a memory read (S_EMIT_WAIT),
//   then an output load (S_EMIT_OUT) once the slot is free, while the input is held off
// a stalled result holds the input off; the input is taken on the cycle the slot drains
// reset clears all control state; the payload buffer is never cleared, only written
// error totals wrap at COUNTER_WIDTH bits and show their low 16 bits
module framed_packet_receiver_crc16
#(
    parameter int MAX_PAYLOAD   = fpr_pkg::DEF_MAX_PAYLOAD,
    parameter int COUNTER_WIDTH = fpr_pkg::DEF_COUNTER_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   rx_byte,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [2:0]                   status,
    output logic [7:0]                   packet_id,
    output logic [7:0]                   sequence_number,
    output logic [5:0]                   payload_count,
    output logic [7:0]                   payload_byte,
    output logic [4:0]                   byte_index,
    output logic                         last,
    output logic [15:0]                  format_errors,
    output logic [15:0]                  version_errors,
    output logic [15:0]                  crc_errors,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                   cfg_data
);
    import fpr_pkg::*;

    // buffer address width; one bit minimum for a single-entry buffer
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    typedef enum logic [2:0] {
        S_HUNT,
        S_MARK2,
        S_HDR,
        S_PAYLOAD,
        S_CRC_LO,
        S_CRC_HI,
        S_EMIT_WAIT,
        S_EMIT_OUT
    } state_t;

    // configuration
    logic [7:0]  sof_first_reg;
    logic [7:0]  sof_second_reg;
    logic [7:0]  exp_version_reg;

    // frame tracking
    state_t      state_reg, state_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  msg_id_reg, msg_id_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [ADDR_W-1:0] emit_idx_reg, emit_idx_next;

    logic [COUNTER_WIDTH-1:0] fmt_cnt_reg, fmt_cnt_next;
    logic [COUNTER_WIDTH-1:0] ver_cnt_reg, ver_cnt_next;
    logic [COUNTER_WIDTH-1:0] crc_cnt_reg, crc_cnt_next;

    // result slot
    logic        out_valid_reg, out_valid_next;
    fpr_status_t status_reg, status_next;
    logic [7:0]  mid_out_reg, mid_out_next;
    logic [7:0]  seq_out_reg, seq_out_next;
    logic [5:0]  count_out_reg, count_out_next;
    logic [7:0]  pbyte_out_reg, pbyte_out_next;
    logic [4:0]  idx_out_reg, idx_out_next;
    logic        last_out_reg, last_out_next;

    // payload buffer
    logic [7:0]  payload_mem [MAX_PAYLOAD];
    logic [7:0]  rd_data_reg;
    logic        mem_we;

    logic        slot_free;
    logic        in_fire;
    logic        load_out;
    logic [15:0] crc_feed_val;
    logic [15:0] rx_crc;
    logic [7:0]  off_plus1;
    logic [7:0]  emit_plus1;
    logic [31:0] fmt_wide;
    logic [31:0] ver_wide;
    logic [31:0] crc_wide;

    assign slot_free = !out_valid_reg || out_ready;
    // no new byte while the buffer plays out a packet
    assign in_ready  = slot_free && (state_reg != S_EMIT_WAIT) && (state_reg != S_EMIT_OUT);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign crc_feed_val = crc16_feed(crc_reg, rx_byte);
    assign rx_crc       = {rx_byte, crc_lo_reg};
    assign off_plus1    = 8'(off_reg) + 8'd1;
    assign emit_plus1   = 8'(emit_idx_reg) + 8'd1;

    always_comb
    begin
        state_next     = state_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        version_next   = version_reg;
        msg_id_next    = msg_id_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        crc_lo_next    = crc_lo_reg;
        off_next       = off_reg;
        emit_idx_next  = emit_idx_reg;
        fmt_cnt_next   = fmt_cnt_reg;
        ver_cnt_next   = ver_cnt_reg;
        crc_cnt_next   = crc_cnt_reg;
        mem_we         = 1'b0;

        // every accepted byte gives a plain result unless an arm below says otherwise
        load_out       = in_fire;
        status_next    = ST_NONE;
        mid_out_next   = 8'd0;
        seq_out_next   = 8'd0;
        count_out_next = 6'd0;
        pbyte_out_next = 8'd0;
        idx_out_next   = 5'd0;
        last_out_next  = 1'b1;

        unique case (state_reg)
            S_HUNT:
            begin
                if (in_fire && rx_byte == sof_first_reg)
                    state_next = S_MARK2;
            end
            S_MARK2:
            begin
                if (in_fire)
                begin
                    if (rx_byte == sof_second_reg)
                    begin
                        state_next   = S_HDR;
                        hdr_cnt_next = 2'd0;
                        crc_next     = CRC_INIT;
                    end
                    else if (rx_byte == sof_first_reg)
                        state_next = S_MARK2;
                    else
                        state_next = S_HUNT;
                end
            end
            S_HDR:
            begin
                if (in_fire)
                begin
                    crc_next     = crc_feed_val;
                    hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    unique case (hdr_cnt_reg)
                        2'd0: version_next = rx_byte;
                        2'd1: msg_id_next  = rx_byte;
                        2'd2: seq_next     = rx_byte;
                        2'd3: len_next     = rx_byte;
                        default: version_next = rx_byte;
                    endcase
                    if (hdr_cnt_reg == 2'd3)
                    begin
                        off_next = '0;
                        if (rx_byte > 8'(MAX_PAYLOAD))
                        begin
                            // oversize length: report now, the length byte may start a frame
                            status_next  = ST_FORMAT;
                            fmt_cnt_next = fmt_cnt_reg + 1'b1;
                            state_next   = (rx_byte == sof_first_reg) ? S_MARK2 : S_HUNT;
                        end
                        else if (rx_byte == 8'd0)
                            state_next = S_CRC_LO;
                        else
                            state_next = S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD:
            begin
                if (in_fire)
                begin
                    mem_we   = 1'b1;
                    crc_next = crc_feed_val;
                    off_next = off_reg + 1'b1;
                    if (off_plus1 == len_reg)
                        state_next = S_CRC_LO;
                end
            end
            S_CRC_LO:
            begin
                if (in_fire)
                begin
                    crc_lo_next = rx_byte;
                    state_next  = S_CRC_HI;
                end
            end
            S_CRC_HI:
            begin
                if (in_fire)
                begin
                    state_next = S_HUNT;
                    // version is judged first, the crc only on a matching version
                    if (version_reg != exp_version_reg)
                    begin
                        status_next  = ST_VERSION;
                        ver_cnt_next = ver_cnt_reg + 1'b1;
                    end
                    else if (rx_crc != crc_reg)
                    begin
                        status_next  = ST_CRC;
                        crc_cnt_next = crc_cnt_reg + 1'b1;
                    end
                    else if (len_reg == 8'd0)
                    begin
                        status_next  = ST_PACKET;
                        mid_out_next = msg_id_reg;
                        seq_out_next = seq_reg;
                    end
                    else
                    begin
                        // payload run comes from the buffer
                        load_out      = 1'b0;
                        emit_idx_next = '0;
                        state_next    = S_EMIT_WAIT;
                    end
                end
            end
            S_EMIT_WAIT:
            begin
                // buffer read of emit_idx_reg lands in rd_data_reg
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    status_next    = ST_PACKET;
                    mid_out_next   = msg_id_reg;
                    seq_out_next   = seq_reg;
                    count_out_next = len_reg[5:0];
                    pbyte_out_next = rd_data_reg;
                    idx_out_next   = 5'(emit_idx_reg);
                    last_out_next  = (emit_plus1 == len_reg);
                    if (emit_plus1 == len_reg)
                        state_next = S_HUNT;
                    else
                    begin
                        emit_idx_next = emit_idx_reg + 1'b1;
                        state_next    = S_EMIT_WAIT;
                    end
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state, configuration and the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_first_reg   <= SOF_FIRST_RST;
            sof_second_reg  <= SOF_SECOND_RST;
            exp_version_reg <= EXP_VERSION_RST;
            state_reg       <= S_HUNT;
            hdr_cnt_reg     <= 2'd0;
            version_reg     <= 8'd0;
            msg_id_reg      <= 8'd0;
            seq_reg         <= 8'd0;
            len_reg         <= 8'd0;
            crc_reg         <= CRC_INIT;
            crc_lo_reg      <= 8'd0;
            off_reg         <= '0;
            emit_idx_reg    <= '0;
            fmt_cnt_reg     <= '0;
            ver_cnt_reg     <= '0;
            crc_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SOF_FIRST:   sof_first_reg   <= cfg_data;
                    CFG_SOF_SECOND:  sof_second_reg  <= cfg_data;
                    CFG_EXP_VERSION: exp_version_reg <= cfg_data;
                    default:         ;
                endcase
            end
            state_reg     <= state_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            version_reg   <= version_next;
            msg_id_reg    <= msg_id_next;
            seq_reg       <= seq_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            crc_lo_reg    <= crc_lo_next;
            off_reg       <= off_next;
            emit_idx_reg  <= emit_idx_next;
            fmt_cnt_reg   <= fmt_cnt_next;
            ver_cnt_reg   <= ver_cnt_next;
            crc_cnt_reg   <= crc_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg    <= status_next;
            mid_out_reg   <= mid_out_next;
            seq_out_reg   <= seq_out_next;
            count_out_reg <= count_out_next;
            pbyte_out_reg <= pbyte_out_next;
            idx_out_reg   <= idx_out_next;
            last_out_reg  <= last_out_next;
        end
    end

    // payload buffer: one write port, one registered read port
    // the last payload write comes ahead of the first read, with both crc bytes in between
    always_ff @(posedge clk)
    begin
        if (mem_we)
            payload_mem[off_reg] <= rx_byte;
        rd_data_reg <= payload_mem[emit_idx_reg];
    end

    // totals change only with an input transfer, so a held result stays consistent
    assign fmt_wide = 32'(fmt_cnt_reg);
    assign ver_wide = 32'(ver_cnt_reg);
    assign crc_wide = 32'(crc_cnt_reg);

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign packet_id       = mid_out_reg;
    assign sequence_number = seq_out_reg;
    assign payload_count   = count_out_reg;
    assign payload_byte    = pbyte_out_reg;
    assign byte_index      = idx_out_reg;
    assign last            = last_out_reg;
    assign format_errors   = fmt_wide[15:0];
    assign version_errors  = ver_wide[15:0];
    assign crc_errors      = crc_wide[15:0];

endmodule

FILE: hw/rtl/fpr_checker.sv
// port-level checks for the frame receiver, attached by bind
// depends on fpr_pkg and framed_packet_receiver_crc16
module fpr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [5:0]  payload_count,
    input logic [7:0]  payload_byte,
    input logic [4:0]  byte_index,
    input logic        last,
    input logic [15:0] format_errors,
    input logic [15:0] version_errors,
    input logic [15:0] crc_errors
);
    import fpr_pkg::*;

    // a held result blocks the input
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while a result is stalled");

    // a stalled result keeps its payload
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(payload_byte)
                                       && $stable(byte_index) && $stable(last)))
        else $error("stalled result changed");

    // anything but a packet is a single result with empty payload fields
    a_non_packet_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_PACKET) |->
            (last && payload_byte == 8'd0 && byte_index == 5'd0 && payload_count == 6'd0))
        else $error("non-packet result carries payload fields");

    // totals move only with an input transfer
    a_totals_need_input: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) |=>
            ($stable(format_errors) && $stable(version_errors) && $stable(crc_errors)))
        else $error("error total changed without an input transfer");

endmodule

bind framed_packet_receiver_crc16 fpr_checker u_fpr_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .payload_count  (payload_count),
    .payload_byte   (payload_byte),
    .byte_index     (byte_index),
    .last           (last),
    .format_errors  (format_errors),
    .version_errors (version_errors),
    .crc_errors     (crc_errors)
);

FILE: test/tb_top.sv
// self-checking bench for framed_packet_receiver_crc16: marker hunt, header, payload run,
// crc check and the three wrapping error totals, under random stalls on both channels
// depends on fpr_pkg and the receiver rtl; frames are built here and predicted by frame_tracker
`timescale 1ns / 1ps

module tb_top;

    import fpr_pkg::*;

    // one result transfer as seen on the output channel
    typedef struct packed {
        fpr_status_t status;
        logic [7:0]  packet_id;
        logic [7:0]  sequence_number;
        logic [5:0]  payload_count;
        logic [7:0]  payload_byte;
        logic [4:0]  byte_index;
        logic        last;
        logic [15:0] format_errors;
        logic [15:0] version_errors;
        logic [15:0] crc_errors;
    } frame_result_t;

    // mirror of the receiver: tracks the frame byte by byte and queues the results it owes
    class frame_tracker;
        localparam int HDR_START  = 2;
        localparam int HDR_LEN    = 4;
        localparam int BODY_START = 6;
        localparam int MAX_BODY   = DEF_MAX_PAYLOAD;

        bit [7:0]      sof_first;
        bit [7:0]      sof_second;
        bit [7:0]      want_version;
        int            pos;
        bit [7:0]      hdr [HDR_LEN];
        bit [7:0]      body [MAX_BODY];
        bit [15:0]     crc;
        bit [7:0]      crc_lo;
        bit [15:0]     fmt_total;
        bit [15:0]     ver_total;
        bit [15:0]     crc_total;
        frame_result_t pending [$];
        int            mismatches;

        function new();
            sof_first    = SOF_FIRST_RST;
            sof_second   = SOF_SECOND_RST;
            want_version = EXP_VERSION_RST;
            pos          = 0;
            foreach (hdr[i]) hdr[i] = 8'h00;
            crc          = CRC_INIT;
            crc_lo       = 8'h00;
            fmt_total    = 16'h0000;
            ver_total    = 16'h0000;
            crc_total    = 16'h0000;
            mismatches   = 0;
        endfunction

        // msb first, no reflection, no final xor
        static function bit [15:0] crc_step(bit [15:0] c, bit [7:0] b);
            bit [15:0] r;
            r = c ^ {b, 8'h00};
            repeat (8)
            begin
                r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
            end
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_SOF_FIRST:   sof_first    = val;
                CFG_SOF_SECOND:  sof_second   = val;
                CFG_EXP_VERSION: want_version = val;
                default:         ;
            endcase
        endfunction

        function void push(fpr_status_t st, bit [7:0] mid, bit [7:0] seq, bit [5:0] cnt,
                           bit [7:0] pb, bit [4:0] idx, bit lst);
            frame_result_t r;
            r.status          = st;
            r.packet_id       = mid;
            r.sequence_number = seq;
            r.payload_count   = cnt;
            r.payload_byte    = pb;
            r.byte_index      = idx;
            r.last            = lst;
            r.format_errors   = fmt_total;
            r.version_errors  = ver_total;
            r.crc_errors      = crc_total;
            pending.push_back(r);
        endfunction

        function void push_status(fpr_status_t st);
            push(st, 8'h00, 8'h00, 6'd0, 8'h00, 5'd0, 1'b1);
        endfunction

        // called for every accepted input byte
        function void take_byte(bit [7:0] b);
            int body_len;
            int off;
            if (pos == 0)
            begin
                if (b == sof_first)
                    pos = 1;
                push_status(ST_NONE);
            end
            else if (pos == 1)
            begin
                // a repeated first marker keeps the hunt one byte in
                if (b == sof_second)
                begin
                    pos = HDR_START;
                    crc = CRC_INIT;
                end
                else
                    pos = (b == sof_first) ? 1 : 0;
                push_status(ST_NONE);
            end
            else if (pos < BODY_START)
            begin
                hdr[pos - HDR_START] = b;
                crc = crc_step(crc, b);
                pos++;
                if (pos == BODY_START && b > MAX_BODY)
                begin
                    fmt_total++;
                    pos = (b == sof_first) ? 1 : 0;
                    push_status(ST_FORMAT);
                end
                else
                    push_status(ST_NONE);
            end
            else
            begin
                body_len = hdr[3];
                off      = pos - BODY_START;
                if (off < body_len)
                begin
                    body[off] = b;
                    crc = crc_step(crc, b);
                    pos++;
                    push_status(ST_NONE);
                end
                else if (off == body_len)
                begin
                    crc_lo = b;
                    pos++;
                    push_status(ST_NONE);
                end
                else
                begin
                    // frame complete: version first, then crc, then the payload run
                    pos = 0;
                    if (hdr[0] != want_version)
                    begin
                        ver_total++;
                        push_status(ST_VERSION);
                    end
                    else if ({b, crc_lo} != crc)
                    begin
                        crc_total++;
                        push_status(ST_CRC);
                    end
                    else if (body_len == 0)
                        push(ST_PACKET, hdr[1], hdr[2], 6'd0, 8'h00, 5'd0, 1'b1);
                    else
                        for (int i = 0; i < body_len; i++)
                            push(ST_PACKET, hdr[1], hdr[2], 6'(body_len), body[i], 5'(i),
                                 i == body_len - 1);
                end
            end
        endfunction

        function string show(frame_result_t r);
            return $sformatf({"st=%0d id=%02h seq=%02h cnt=%0d pb=%02h idx=%0d last=%0b",
                              " fe=%0d ve=%0d ce=%0d"},
                             r.status, r.packet_id, r.sequence_number, r.payload_count,
                             r.payload_byte, r.byte_index, r.last, r.format_errors,
                             r.version_errors, r.crc_errors);
        endfunction

        // called for every accepted result
        function void check_result(frame_result_t got);
            frame_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t: %s", $realtime, show(got));
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.packet_id !== want.packet_id ||
                got.sequence_number !== want.sequence_number ||
                got.payload_count !== want.payload_count ||
                got.payload_byte !== want.payload_byte || got.byte_index !== want.byte_index ||
                got.last !== want.last || got.format_errors !== want.format_errors ||
                got.version_errors !== want.version_errors ||
                got.crc_errors !== want.crc_errors)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function bit failed();
            return mismatches != 0 || pending.size() != 0;
        endfunction
    endclass

    // clock, reset and every block input start at known values
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic [7:0]           rx_byte   = 8'h00;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SOF_FIRST;
    logic [7:0]           cfg_data  = 8'h00;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  status;
    logic [7:0]  packet_id;
    logic [7:0]  sequence_number;
    logic [5:0]  payload_count;
    logic [7:0]  payload_byte;
    logic [4:0]  byte_index;
    logic        last;
    logic [15:0] format_errors;
    logic [15:0] version_errors;
    logic [15:0] crc_errors;
    logic        cfg_ready;

    frame_tracker book = new();
    bit [7:0]     tx_bytes [$];  // bytes waiting to be sent
    bit           calm = 1'b0;   // when set neither side idles

    framed_packet_receiver_crc16 u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .packet_id       (packet_id),
        .sequence_number (sequence_number),
        .payload_count   (payload_count),
        .payload_byte    (payload_byte),
        .byte_index      (byte_index),
        .last            (last),
        .format_errors   (format_errors),
        .version_errors  (version_errors),
        .crc_errors      (crc_errors),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #6 clk = ~clk;

    // all three channels sampled at the edge, before any of this edge's updates land;
    // config and input transfers are booked before the result check of the same edge
    always @(posedge clk)
    begin : watch
        frame_result_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                book.take_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                got.status          = fpr_status_t'(status);
                got.packet_id       = packet_id;
                got.sequence_number = sequence_number;
                got.payload_count   = payload_count;
                got.payload_byte    = payload_byte;
                got.byte_index      = byte_index;
                got.last            = last;
                got.format_errors   = format_errors;
                got.version_errors  = version_errors;
                got.crc_errors      = crc_errors;
                book.check_result(got);
            end
        end
    end

    // result side back-pressure, out_ready low about 36 percent of the time
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 36);
    end

    // one input transfer; valid stays up afterwards for back-to-back bytes
    task automatic send_byte(input bit [7:0] b);
        bit paused;
        paused = 1'b0;
        while (!calm && $urandom_range(99) < 36)
        begin
            if (!paused)
                in_valid <= 1'b0;
            paused = 1'b1;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_queued();
        foreach (tx_bytes[i])
            send_byte(tx_bytes[i]);
        tx_bytes.delete();
    endtask

    // sender holds off until every owed result has come out, then a short settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // queue a frame under the current markers; fill < 0 means random payload
    function automatic void build_frame(bit [7:0] ver, bit [7:0] mid, bit [7:0] seq,
                                        bit [7:0] len, bit corrupt, int fill);
        bit [7:0]  head [4];
        bit [7:0]  b;
        bit [15:0] c;
        head = '{ver, mid, seq, len};
        c    = CRC_INIT;
        tx_bytes.push_back(book.sof_first);
        tx_bytes.push_back(book.sof_second);
        foreach (head[i])
        begin
            tx_bytes.push_back(head[i]);
            c = frame_tracker::crc_step(c, head[i]);
        end
        // oversize length: the receiver drops the frame right here
        if (len > DEF_MAX_PAYLOAD)
            return;
        for (int i = 0; i < len; i++)
        begin
            b = (fill < 0) ? 8'($urandom) : 8'(fill);
            tx_bytes.push_back(b);
            c = frame_tracker::crc_step(c, b);
        end
        if (corrupt)
            c ^= 16'($urandom_range(65535, 1));
        tx_bytes.push_back(c[7:0]);
        tx_bytes.push_back(c[15:8]);
    endfunction

    // mostly well-formed frames, the rest broken starts and line noise
    function automatic void add_random_chunk();
        int       pick;
        int       n;
        bit [7:0] ver;
        bit [7:0] len;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            ver = ($urandom_range(9) == 0) ? 8'($urandom) : book.want_version;
            n   = $urandom_range(99);
            if (n < 55)
                len = 8'($urandom_range(3));
            else if (n < 82)
                len = 8'($urandom_range(12, 4));
            else if (n < 94)
                len = 8'($urandom_range(32, 13));
            else
                len = 8'($urandom_range(255, 33));
            build_frame(ver, 8'($urandom), 8'($urandom), len, $urandom_range(7) == 0, -1);
        end
        else if (pick < 85)
        begin
            tx_bytes.push_back(book.sof_first);
            tx_bytes.push_back($urandom_range(1) ? book.sof_first : 8'($urandom));
            if ($urandom_range(1))
            begin
                tx_bytes.push_back(book.sof_second);
                repeat ($urandom_range(3, 1)) tx_bytes.push_back(8'($urandom));
            end
        end
        else
        begin
            repeat ($urandom_range(3, 1)) tx_bytes.push_back(8'($urandom));
        end
    endfunction

    initial
    begin : stimulus
        bit [7:0] first_val;
        bit [7:0] second_val;
        bit [7:0] ver_val;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // marker mismatch, then a repeated first marker before a one-byte frame
        tx_bytes.push_back(SOF_FIRST_RST);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(SOF_FIRST_RST);
        build_frame(EXP_VERSION_RST, 8'hFF, 8'h00, 8'd1, 1'b0, 8'hFF);
        // oversize length that is itself the first marker, feeding a wrong-version frame
        tx_bytes.push_back(SOF_FIRST_RST);
        tx_bytes.push_back(SOF_SECOND_RST);
        tx_bytes.push_back(EXP_VERSION_RST);
        tx_bytes.push_back(8'h12);
        tx_bytes.push_back(8'h34);
        build_frame(8'h02, 8'h00, 8'h00, 8'd0, 1'b0, 0);
        // crc mismatch on an empty frame
        build_frame(EXP_VERSION_RST, 8'h00, 8'hFF, 8'd0, 1'b1, 0);
        send_queued();

        // registers changed while a frame is half received
        send_byte(SOF_FIRST_RST);
        wait_drained();
        write_reg(CFG_SOF_SECOND, 8'h5A);
        tx_bytes = {8'h5A, EXP_VERSION_RST, 8'h00, 8'h00, 8'h00, 8'h77};
        send_queued();
        wait_drained();
        write_reg(CFG_EXP_VERSION, 8'h00);
        send_byte(8'h88);
        wait_drained();

        // random phases, each under its own register setting, reset values and extremes first
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:
                begin
                    first_val  = SOF_FIRST_RST;
                    second_val = SOF_SECOND_RST;
                    ver_val    = EXP_VERSION_RST;
                end
                1:
                begin
                    first_val  = 8'h00;
                    second_val = 8'hFF;
                    ver_val    = 8'h00;
                end
                2:
                begin
                    first_val  = 8'hFF;
                    second_val = 8'h00;
                    ver_val    = 8'hFF;
                end
                3:
                begin
                    // both markers equal
                    first_val  = 8'($urandom);
                    second_val = first_val;
                    ver_val    = 8'($urandom);
                end
                default:
                begin
                    first_val  = 8'($urandom);
                    second_val = 8'($urandom);
                    ver_val    = 8'($urandom);
                end
            endcase
            write_reg(CFG_SOF_FIRST, first_val);
            write_reg(CFG_SOF_SECOND, second_val);
            write_reg(CFG_EXP_VERSION, ver_val);

            // full-size payload once, so every byte_index bit toggles
            if (ph == 0)
            begin
                build_frame(ver_val, 8'($urandom), 8'($urandom), 8'(DEF_MAX_PAYLOAD), 1'b0, -1);
                send_queued();
            end

            while (tx_bytes.size() < 6)
                add_random_chunk();
            // sometimes cut the tail so the next setting lands mid-frame
            if ($urandom_range(1))
                while (tx_bytes.size() > 6)
                    void'(tx_bytes.pop_back());
            send_queued();
            wait_drained();
        end

        // back-to-back format errors: an oversize length equal to the first marker
        // restarts the frame at once, five bytes per error, no idling on either side
        write_reg(CFG_SOF_FIRST, SOF_FIRST_RST);
        write_reg(CFG_SOF_SECOND, SOF_SECOND_RST);
        write_reg(CFG_EXP_VERSION, EXP_VERSION_RST);
        calm = 1'b1;
        send_byte(SOF_FIRST_RST);
        repeat (5)
        begin
            send_byte(SOF_SECOND_RST);
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            send_byte(8'($urandom));
            send_byte(SOF_FIRST_RST);
        end
        calm = 1'b0;
        send_byte(SOF_SECOND_RST);
        tx_bytes.push_back(EXP_VERSION_RST);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'd2);
        tx_bytes.push_back(8'hC3);
        tx_bytes.push_back(8'h3C);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'h00);
        build_frame(EXP_VERSION_RST, 8'($urandom), 8'($urandom), 8'd3, 1'b0, -1);
        send_queued();
        wait_drained();

        if (book.failed())
            $display("FAIL");
        else
            $display("PASS");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
